// ===== design/kmp_pkg.sv =====
// Shared types, constants and the sequencer microcode for the shortest-period block.
// Depends on nothing; every other design file but kmp_ram imports it.
package kmp_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int POS_W    = ADDR_W + 1;
    localparam int CH_W     = 8;
    localparam int PERIOD_W = 13;
    localparam int STEP_W   = 4;
    localparam int COND_W   = 4;
    localparam int ELSE_W   = 2;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [COND_W-1:0] cond_t;
    typedef logic [ELSE_W-1:0] else_t;

    // Branch conditions
    localparam cond_t C_ALWAYS   = 4'd0;
    localparam cond_t C_ACCEPT   = 4'd1;
    localparam cond_t C_FULL     = 4'd2;
    localparam cond_t C_POS_ZERO = 4'd3;
    localparam cond_t C_MATCH    = 4'd4;
    localparam cond_t C_K_ZERO   = 4'd5;
    localparam cond_t C_NOT_LAST = 4'd6;
    localparam cond_t C_LAST     = 4'd7;
    localparam cond_t C_OUT_FREE = 4'd8;

    // Where to go when the condition is false
    localparam else_t E_NEXT = 2'd0;
    localparam else_t E_HOLD = 2'd1;
    localparam else_t E_HOME = 2'd2;

    // Program steps
    localparam step_t S_WAIT  = 4'd0;
    localparam step_t S_CHECK = 4'd1;
    localparam step_t S_READ  = 4'd2;
    localparam step_t S_CMP   = 4'd3;
    localparam step_t S_KZERO = 4'd4;
    localparam step_t S_FALL  = 4'd5;
    localparam step_t S_INC   = 4'd6;
    localparam step_t S_WRITE = 4'd7;
    localparam step_t S_FIN   = 4'd8;
    localparam step_t S_OVF   = 4'd9;

    typedef struct packed {
        logic  ready;    // take a request
        logic  rd;       // read text[k] and fail[k-1]
        logic  k_load;   // k <= fail[k-1]
        logic  k_inc;    // k <= k + 1
        logic  wr;       // store byte and failure value, advance position
        logic  set_ovf;  // note a dropped byte
        logic  emit;     // hand out the result when the output slot is free
        cond_t cond;
        step_t target;
        else_t els;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic full;
        logic pos_zero;
        logic match;
        logic k_zero;
        logic last;
        logic out_free;
    } stat_t;

    function automatic ctrl_t mk(logic ready, logic rd, logic k_load, logic k_inc,
                                 logic wr, logic set_ovf, logic emit,
                                 cond_t cond, step_t target, else_t els);
        ctrl_t c;
        c.ready   = ready;
        c.rd      = rd;
        c.k_load  = k_load;
        c.k_inc   = k_inc;
        c.wr      = wr;
        c.set_ovf = set_ovf;
        c.emit    = emit;
        c.cond    = cond;
        c.target  = target;
        c.els     = els;
        return c;
    endfunction

    // Microcode ROM
    function automatic ctrl_t kmp_ucode(step_t step);
        ctrl_t c;
        unique case (step)
            S_WAIT:  c = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_ACCEPT, S_CHECK, E_HOLD);
            S_CHECK: c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_FULL, S_OVF, E_NEXT);
            S_READ:  c = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_POS_ZERO, S_WRITE, E_NEXT);
            S_CMP:   c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_MATCH, S_INC, E_NEXT);
            S_KZERO: c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_K_ZERO, S_WRITE, E_NEXT);
            S_FALL:  c = mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_ALWAYS, S_READ, E_NEXT);
            S_INC:   c = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                            C_ALWAYS, S_WRITE, E_NEXT);
            S_WRITE: c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                            C_NOT_LAST, S_WAIT, E_NEXT);
            S_FIN:   c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                            C_OUT_FREE, S_WAIT, E_HOLD);
            S_OVF:   c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                            C_LAST, S_FIN, E_HOME);
            default: c = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            C_ALWAYS, S_WAIT, E_NEXT);
        endcase
        return c;
    endfunction

endpackage

// ===== design/kmp_if.sv =====
// Valid/ready channel interfaces for byte requests and period results.
// Depends on kmp_pkg for field widths.
interface kmp_in_if
    import kmp_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface kmp_out_if
    import kmp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period;
    logic                overflow;

    modport source (output valid, output period, output overflow, input ready);
    modport sink   (input valid, input period, input overflow, output ready);
endinterface

// ===== design/kmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/kmp_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional branching.
// Depends on kmp_pkg (ctrl_t, stat_t, kmp_ucode).
module kmp_useq
    import kmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  taken;

    assign ctrl = kmp_ucode(step_reg);

    // Condition select
    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   taken = 1'b1;
            C_ACCEPT:   taken = stat.accept;
            C_FULL:     taken = stat.full;
            C_POS_ZERO: taken = stat.pos_zero;
            C_MATCH:    taken = stat.match;
            C_K_ZERO:   taken = stat.k_zero;
            C_NOT_LAST: taken = !stat.last;
            C_LAST:     taken = stat.last;
            C_OUT_FREE: taken = stat.out_free;
            default:    taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (taken)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            unique case (ctrl.els)
                E_NEXT:  step_next = step_reg + step_t'(1);
                E_HOLD:  step_next = step_reg;
                E_HOME:  step_next = S_WAIT;
                default: step_next = S_WAIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== design/kmp_shortest_period.sv =====
// Shortest period of a byte string through the online KMP failure function.
// Steps per byte: the first byte of a string passes wait, check, read and write; a later byte
// also compares, then increments k on a match or tests k for zero, plus a fallback step per
// failure-chain link (a registered RAM read and a compare); a dropped byte past MAX_LEN passes
// check and overflow. The last byte then loads the output register once the output slot is free.
// One byte in work at a time. Reset (rst_n, async low) empties the string; stores are not cleared.
// Depends on kmp_pkg, kmp_if, kmp_ram and kmp_useq.
module kmp_shortest_period
    import kmp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    kmp_in_if.sink         item,
    kmp_out_if.source      result
);

    ctrl_t ctrl;
    stat_t stat;

    logic [CH_W-1:0]     ch_reg;
    logic                last_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [ADDR_W-1:0]   k_reg;
    logic                ovf_reg;
    logic                out_valid_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                out_ovf_reg;

    logic [CH_W-1:0]   text_rdata;
    logic [ADDR_W-1:0] fail_rdata;
    logic              accept;
    logic              emit;
    logic              out_free;

    assign accept   = item.valid && ctrl.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign emit     = ctrl.emit && out_free;

    // Status to the sequencer
    assign stat.accept   = accept;
    assign stat.full     = (pos_reg == POS_W'(MAX_LEN));
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.match    = (text_rdata == ch_reg);
    assign stat.k_zero   = (k_reg == '0);
    assign stat.last     = last_reg;
    assign stat.out_free = out_free;

    kmp_useq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Stored bytes
    kmp_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_text (
        .clk   (clk),
        .we    (ctrl.wr),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (ch_reg),
        .re    (ctrl.rd),
        .raddr (k_reg),
        .rdata (text_rdata)
    );

    // Failure values
    kmp_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_fail (
        .clk   (clk),
        .we    (ctrl.wr),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (k_reg),
        .re    (ctrl.rd),
        .raddr (k_reg - ADDR_W'(1)),
        .rdata (fail_rdata)
    );

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= item.ch;
            last_reg <= item.last;
        end
    end

    // Position, match length and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            k_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (emit)
        begin
            pos_reg <= '0;
            k_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.k_load)
            begin
                k_reg <= fail_rdata;
            end
            else if (ctrl.k_inc)
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
            if (ctrl.wr)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            if (ctrl.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            period_reg  <= PERIOD_W'(pos_reg - POS_W'(k_reg));
            out_ovf_reg <= ovf_reg;
        end
    end

    assign item.ready      = ctrl.ready;
    assign result.valid    = out_valid_reg;
    assign result.period   = period_reg;
    assign result.overflow = out_ovf_reg;

endmodule

// ===== design/kmp_checker.sv =====
// Port-level checks on the shortest-period block, attached by bind.
// Depends on kmp_pkg and on the top level's interface ports.
module kmp_checker
    import kmp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic [PERIOD_W-1:0] res_period,
    input logic                res_overflow
);

    // Nothing shows on the result side while in reset
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // A period is never zero and never beyond the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_period != '0) && (res_period <= PERIOD_W'(MAX_LEN)))
        else $error("period out of range");

    // One byte at a time: ready drops after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken while previous byte still in work");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_period) && $stable(res_overflow))
        else $error("stalled result changed");

endmodule

bind kmp_shortest_period kmp_checker u_kmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_period   (result.period),
    .res_overflow (result.overflow)
);
